// File: design/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg
// shared types, register map and reset values for the debounce click counter
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int unsigned AddrWidth   = 4;
    localparam int unsigned DataWidth   = 32;
    localparam int unsigned TickWidth   = 16;
    localparam int unsigned CountWidth  = 32;
    localparam int unsigned TallyWidth  = 8;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_SWITCH_MODE    = 2'd0;
    localparam logic [1:0] REG_IDLE_HIGH      = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd2;
    localparam logic [1:0] REG_REPEAT_TICKS   = 2'd3;

    localparam logic                 RST_SWITCH_MODE    = 1'b0;
    localparam logic                 RST_IDLE_HIGH      = 1'b1;
    localparam logic [TickWidth-1:0] RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [TickWidth-1:0] RST_REPEAT_TICKS   = 16'd500;

    // event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_CHANGED  = 2'd1;
    localparam logic [1:0] EV_PRESSED  = 2'd2;
    localparam logic [1:0] EV_RELEASED = 2'd3;

    typedef struct packed {
        logic                 switch_mode;
        logic                 idle_high;
        logic [TickWidth-1:0] debounce_ticks;
        logic [TickWidth-1:0] repeat_ticks;
    } t_cfg;

endpackage

// File: design/button_debounce_click_counter.sv
// path: an accepted item sits in the input register and then moves into the result
// register, from which its result is offered; a stalled output holds it there
// throughput: one tick item per cycle while the output is not stalled, set by the single-pass state update
// reset: synchronous active-low i_rst_n clears the valid flags of both stages and the
// tick state and loads the configuration registers with their default values
// ----------------------------------------------------------------------------
// button_debounce_click_counter
// debounces a sampled pin and reports switch changes or button click series
// ----------------------------------------------------------------------------
module button_debounce_click_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdcc_pkg::AddrWidth-1:0]  paddr,
    input  logic [bdcc_pkg::DataWidth-1:0]  pwdata,
    output logic [bdcc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pin_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_event_kind,
    output logic [bdcc_pkg::TallyWidth-1:0] o_click_count,
    output logic [bdcc_pkg::CountWidth-1:0] o_hold_length,
    output logic                            o_is_pressed
);

    bdcc_pkg::t_cfg w_cfg;

    bdcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bdcc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pin_level   (i_pin_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_click_count (o_click_count),
        .o_hold_length (o_hold_length),
        .o_is_pressed  (o_is_pressed)
    );

endmodule

// File: design/bdcc_regs.sv
// ----------------------------------------------------------------------------
// bdcc_regs
// apb configuration registers, always ready, read back of current values
// ----------------------------------------------------------------------------
module bdcc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdcc_pkg::AddrWidth-1:0] paddr,
    input  logic [bdcc_pkg::DataWidth-1:0] pwdata,
    output logic [bdcc_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    output bdcc_pkg::t_cfg                o_cfg
);

    bdcc_pkg::t_cfg r_cfg;
    logic [1:0]     w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_mode    <= bdcc_pkg::RST_SWITCH_MODE;
            r_cfg.idle_high      <= bdcc_pkg::RST_IDLE_HIGH;
            r_cfg.debounce_ticks <= bdcc_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.repeat_ticks   <= bdcc_pkg::RST_REPEAT_TICKS;
        end else if (w_wr) begin
            case (w_idx)
                bdcc_pkg::REG_SWITCH_MODE:    r_cfg.switch_mode    <= pwdata[0];
                bdcc_pkg::REG_IDLE_HIGH:      r_cfg.idle_high      <= pwdata[0];
                bdcc_pkg::REG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= pwdata[bdcc_pkg::TickWidth-1:0];
                end
                bdcc_pkg::REG_REPEAT_TICKS: begin
                    r_cfg.repeat_ticks <= pwdata[bdcc_pkg::TickWidth-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bdcc_pkg::REG_SWITCH_MODE: begin
                prdata = {{(bdcc_pkg::DataWidth-1){1'b0}}, r_cfg.switch_mode};
            end
            bdcc_pkg::REG_IDLE_HIGH: begin
                prdata = {{(bdcc_pkg::DataWidth-1){1'b0}}, r_cfg.idle_high};
            end
            bdcc_pkg::REG_DEBOUNCE_TICKS: begin
                prdata = {{(bdcc_pkg::DataWidth-bdcc_pkg::TickWidth){1'b0}},
                          r_cfg.debounce_ticks};
            end
            bdcc_pkg::REG_REPEAT_TICKS: begin
                prdata = {{(bdcc_pkg::DataWidth-bdcc_pkg::TickWidth){1'b0}},
                          r_cfg.repeat_ticks};
            end
            default: prdata = '0;
        endcase
    end

endmodule

// File: design/bdcc_core.sv
// ----------------------------------------------------------------------------
// bdcc_core
// input register, debounce and click state update, result register
// ----------------------------------------------------------------------------
module bdcc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdcc_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pin_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_event_kind,
    output logic [bdcc_pkg::TallyWidth-1:0] o_click_count,
    output logic [bdcc_pkg::CountWidth-1:0] o_hold_length,
    output logic                            o_is_pressed
);

    localparam logic [bdcc_pkg::CountWidth-1:0] CountMax = '1;
    localparam logic [bdcc_pkg::TallyWidth-1:0] TallyMax = '1;

    // input stage
    logic r_in_valid;
    logic r_in_pin;

    // per-tick state
    logic                            r_stable;
    logic                            r_first;
    logic                            r_active;
    logic [bdcc_pkg::TickWidth-1:0]  r_timer;
    logic                            r_rel_pend;
    logic                            r_restart;
    logic [bdcc_pkg::CountWidth-1:0] r_since;
    logic [bdcc_pkg::CountWidth-1:0] r_held;
    logic [bdcc_pkg::TallyWidth-1:0] r_tally;

    logic                            n_stable;
    logic                            n_active;
    logic [bdcc_pkg::TickWidth-1:0]  n_timer;
    logic                            n_rel_pend;
    logic                            n_restart;
    logic [bdcc_pkg::CountWidth-1:0] n_since;
    logic [bdcc_pkg::CountWidth-1:0] n_held;
    logic [bdcc_pkg::TallyWidth-1:0] n_tally;
    logic [1:0]                      n_event;

    // result stage
    logic                            r_out_valid;
    logic [1:0]                      r_event;
    logic [bdcc_pkg::TallyWidth-1:0] r_count;
    logic [bdcc_pkg::CountWidth-1:0] r_hold;
    logic                            r_pressed;

    logic w_out_free;
    logic w_move;
    logic w_stable0;
    logic w_diff;
    logic w_active0;
    logic [bdcc_pkg::TickWidth-1:0] w_timer0;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_move     = r_in_valid & w_out_free;
    assign o_in_stall = r_in_valid & ~w_out_free;

    // first tick picks the starting level
    assign w_stable0 = r_first ? (i_cfg.switch_mode ? r_in_pin : i_cfg.idle_high) : r_stable;
    assign w_diff    = r_in_pin ^ w_stable0;
    assign w_active0 = r_active | w_diff;
    assign w_timer0  = r_active ? r_timer : '0;

    always_comb begin
        n_stable   = w_stable0;
        n_active   = w_active0;
        n_timer    = w_timer0;
        n_rel_pend = r_rel_pend;
        n_restart  = r_restart;
        n_since    = (r_since == CountMax) ? r_since : r_since + 1'b1;
        n_held     = r_held;
        n_tally    = r_tally;
        n_event    = bdcc_pkg::EV_NONE;

        if (w_active0) begin
            if (w_timer0 >= i_cfg.debounce_ticks) begin
                n_active = 1'b0;
                n_timer  = '0;
                if (w_diff) begin
                    n_stable = ~w_stable0;
                    if (i_cfg.switch_mode) begin
                        n_event = bdcc_pkg::EV_CHANGED;
                    end else if (~w_stable0 == i_cfg.idle_high) begin
                        n_held     = n_since;
                        n_rel_pend = 1'b1;
                    end else begin
                        n_event    = bdcc_pkg::EV_PRESSED;
                        n_since    = '0;
                        n_held     = '0;
                        n_rel_pend = 1'b0;
                        if (r_restart) begin
                            n_tally   = {{(bdcc_pkg::TallyWidth-1){1'b0}}, 1'b1};
                            n_restart = 1'b0;
                        end else if (r_tally != TallyMax) begin
                            n_tally = r_tally + 1'b1;
                        end
                    end
                end
            end else begin
                n_timer = w_timer0 + 1'b1;
            end
        end

        // series closes once the repeat window has run out
        if (n_rel_pend && (n_since > {{(bdcc_pkg::CountWidth-bdcc_pkg::TickWidth){1'b0}},
                                      i_cfg.repeat_ticks})) begin
            n_rel_pend = 1'b0;
            n_restart  = 1'b1;
            n_event    = bdcc_pkg::EV_RELEASED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_pin <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b1;
            r_first    <= 1'b1;
            r_active   <= 1'b0;
            r_timer    <= '0;
            r_rel_pend <= 1'b0;
            r_restart  <= 1'b1;
            r_since    <= '0;
            r_held     <= '0;
            r_tally    <= '0;
        end else if (w_move) begin
            r_stable   <= n_stable;
            r_first    <= 1'b0;
            r_active   <= n_active;
            r_timer    <= n_timer;
            r_rel_pend <= n_rel_pend;
            r_restart  <= n_restart;
            r_since    <= n_since;
            r_held     <= n_held;
            r_tally    <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_event   <= n_event;
            r_count   <= n_tally;
            r_hold    <= n_held;
            r_pressed <= n_stable ^ i_cfg.idle_high;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_event;
    assign o_click_count = r_count;
    assign o_hold_length = r_hold;
    assign o_is_pressed  = r_pressed;

endmodule
